### hdl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Item types, command and status codes for the sorted integer set table.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_BAD_POS = 2'd2;

  typedef enum logic [1:0] {
    OP_INS,
    OP_QRY,
    OP_REM,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic [4:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] count;
  } out_item_t;

  typedef struct packed {
    op_kind_t           kind;
    logic signed [31:0] value;
    logic [4:0]         position;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_head_t;

endpackage

### hdl/sis_chan_if.sv
// ----------------------------------------------------------------------------
// sis_chan_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface sis_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/sis_front.sv
// ----------------------------------------------------------------------------
// sis_front
// Accepts command items, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sis_front (
  input  logic             clk,
  input  logic             rst_n,
  sis_chan_if.sink         in_ch,
  output sis_pkg::op_head_t head,
  input  logic             head_take
);

  sis_pkg::op_t q_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push, pop;
  sis_pkg::op_t dec;

  always_comb begin
    dec.value    = in_ch.data.value;
    dec.position = in_ch.data.position;
    unique case (in_ch.data.cmd)
      sis_pkg::CMD_INSERT: dec.kind = sis_pkg::OP_INS;
      sis_pkg::CMD_QUERY:  dec.kind = sis_pkg::OP_QRY;
      sis_pkg::CMD_REMOVE: dec.kind = sis_pkg::OP_REM;
      default:             dec.kind = sis_pkg::OP_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = head_take && (cnt_r != 2'd0);
  assign head.valid  = (cnt_r != 2'd0);
  assign head.op     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

### hdl/sis_cells.sv
// ----------------------------------------------------------------------------
// sis_cells
// Row of compare-and-shift cells holding the sorted entries; executes one
// command at a time and drives the result register.
// ----------------------------------------------------------------------------
module sis_cells #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sis_pkg::op_head_t head,
  output logic              head_take,
  sis_chan_if.source        out_ch
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = (CW > 5) ? CW : 5;
  localparam int NGRP = (CAPACITY + 31) / 32;

  localparam logic [1:0] ST_EXEC = 2'd0;
  localparam logic [1:0] ST_RED1 = 2'd1;
  localparam logic [1:0] ST_RED2 = 2'd2;

  logic signed [31:0]  ent_r [CAPACITY];
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [1:0]          state_r, state_nxt;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic [NGRP-1:0]     grp_r, grp_nxt;
  logic                out_valid_r, out_valid_nxt;
  sis_pkg::out_item_t  out_r, out_nxt;

  logic                out_free;
  logic                full;
  logic                pos_ok;
  logic                ins_en, rem_en;
  logic [PW-1:0]       pos_w;
  logic [CAPACITY-1:0] gt;

  assign out_free = !out_valid_r || out_ch.ready;
  assign full     = (cnt_r == CW'(CAPACITY));
  assign pos_w    = PW'(head.op.position);
  assign pos_ok   = (pos_w != '0) && (pos_w <= PW'(cnt_r));

  always_comb begin
    head_take     = 1'b0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    ins_en        = 1'b0;
    rem_en        = 1'b0;
    unique case (state_r)
      ST_EXEC: begin
        if (head.valid && head.op.kind == sis_pkg::OP_QRY) begin
          head_take = 1'b1;
          state_nxt = ST_RED1;
        end else if (head.valid && out_free) begin
          head_take      = 1'b1;
          out_valid_nxt  = 1'b1;
          out_nxt.status = sis_pkg::STAT_OK;
          out_nxt.found  = 1'b0;
          unique case (head.op.kind)
            sis_pkg::OP_INS: begin
              if (full) begin
                out_nxt.status = sis_pkg::STAT_FULL;
              end else begin
                ins_en  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            sis_pkg::OP_REM: begin
              if (!pos_ok) begin
                out_nxt.status = sis_pkg::STAT_BAD_POS;
              end else begin
                rem_en  = 1'b1;
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            default: begin
            end
          endcase
          out_nxt.count = 5'(cnt_nxt);
        end
      end
      ST_RED1: begin
        state_nxt = ST_RED2;
      end
      ST_RED2: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = sis_pkg::STAT_OK;
          out_nxt.found  = |grp_r;
          out_nxt.count  = 5'(cnt_r);
          state_nxt      = ST_EXEC;
        end
      end
      default: begin
        state_nxt = ST_EXEC;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic live;
    logic shift_up, take_val, shift_down;
    assign live         = CW'(i) < cnt_r;
    assign gt[i]        = live && (ent_r[i] > head.op.value);
    assign match_nxt[i] = live && (ent_r[i] == head.op.value);

    if (i > 0) begin : g_up
      assign shift_up = gt[i-1];
    end else begin : g_first
      assign shift_up = 1'b0;
    end
    assign take_val = gt[i] || (CW'(i) == cnt_r);
    if (i < CAPACITY - 1) begin : g_down
      assign shift_down = PW'(i + 1) >= pos_w;
    end else begin : g_last
      assign shift_down = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (ins_en) begin
        if (shift_up) begin
          ent_r[i] <= ent_r[(i > 0) ? i - 1 : 0];
        end else if (take_val) begin
          ent_r[i] <= head.op.value;
        end
      end else if (rem_en && shift_down) begin
        ent_r[i] <= ent_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    localparam int LO = g * 32;
    localparam int HI = (LO + 31 < CAPACITY - 1) ? LO + 31 : CAPACITY - 1;
    assign grp_nxt[g] = |match_r[HI:LO];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (state_r == ST_EXEC) begin
      match_r <= match_nxt;
    end
    if (state_r == ST_RED1) begin
      grp_r <= grp_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_en |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow count");

  a_red_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RED1 |=> state_r == ST_RED2)
    else $error("query reduction skipped a stage");

  for (genvar i = 1; i < CAPACITY; i++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (CW'(i) < cnt_r) |-> ent_r[i-1] <= ent_r[i])
      else $error("entries out of order");
  end
`endif

endmodule

### hdl/sorted_int_set_table.sv
// ----------------------------------------------------------------------------
// sorted_int_set_table
// Sorted store of signed 32-bit integers with insert, membership query and
// remove-by-position commands, one result per command.
// ----------------------------------------------------------------------------
//  channel  dir  payload                       handshake
//  in_ch    in   cmd[1:0] value[31:0] pos[4:0]  valid/ready
//  out_ch   out  status[1:0] found count[4:0]   valid/ready
//
//  Insert, remove and the unused code execute directly in the cell row;
//  a query passes through match row, group OR and final OR in order.
//  A two-entry command queue keeps input accepting while a result waits.
//  Reset (rst_n low, synchronous) empties the store at once.
//  A stalled output holds its result; the cell row waits for it to drain.
// ----------------------------------------------------------------------------
module sorted_int_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sis_chan_if.sink   in_ch,
  sis_chan_if.source out_ch
);

  sis_pkg::op_head_t head;
  logic              head_take;

  sis_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .head      (head),
    .head_take (head_take)
  );

  sis_cells #(
    .CAPACITY (CAPACITY)
  ) u_cells (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_take (head_take),
    .out_ch    (out_ch)
  );

endmodule
